FILE: sv/assert_macros.svh
// Assertion macros shared by the segment intersection RTL.
// Every check is clocked on the rising edge of clock and disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every rising clock edge.
`define SSI_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define SSI_ASSERT_NEXT(lbl, cond, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) else $error(msg);

`endif

FILE: sv/ssi_pkg.sv
// Package for the segment intersection block: widths, queue entry and status types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ssi_pkg;
   localparam int CoordWidth   = 16;
   localparam int DiffWidth    = CoordWidth + 1;
   localparam int ProdWidth    = 2 * DiffWidth;
   localparam int SumWidth     = ProdWidth + 1;
   localparam int MagWidth     = SumWidth - 1;
   localparam int QuotWidth    = DiffWidth;
   localparam int NumWidth     = MagWidth + QuotWidth;
   localparam int BaseWidth    = CoordWidth + 2;
   localparam int FifoDepth    = 4;
   localparam int FifoPtrWidth = $clog2(FifoDepth);
   localparam int FifoCntWidth = $clog2(FifoDepth + 1);

   typedef struct packed {
      logic signed [CoordWidth-1:0] p1x;
      logic signed [CoordWidth-1:0] p1y;
      logic [DiffWidth-1:0]         ax_mag;
      logic [DiffWidth-1:0]         ay_mag;
      logic                         neg_x;
      logic                         neg_y;
      logic [MagWidth-1:0]          nr_mag;
      logic [MagWidth-1:0]          dv_mag;
      logic                         hit;
      logic                         want;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;
endpackage
`default_nettype wire

FILE: sv/ssi_front.sv
// Front end: accepts segment pairs, forms the cross products and classifies hits.
// Depends on ssi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ssi_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [127:0]            req_tdata,
   input  wire logic [0:0]              req_tuser,
   input  wire ssi_pkg::fifo_stat_type  fifo_stat,
   output logic                         push,
   output ssi_pkg::job_type             job
);
   localparam int CW = ssi_pkg::CoordWidth;
   localparam int DW = ssi_pkg::DiffWidth;
   localparam int PW = ssi_pkg::ProdWidth;
   localparam int SW = ssi_pkg::SumWidth;
   localparam int MW = ssi_pkg::MagWidth;

   logic fe;
   logic f1_valid_ff, f2_valid_ff, f3_valid_ff;
   logic signed [DW-1:0] ax_ff, ay_ff, bx_ff, by_ff, wx_ff, wy_ff;
   logic signed [DW-1:0] ax2_ff, ay2_ff, ax3_ff, ay3_ff;
   logic signed [CW-1:0] p1x_ff, p1y_ff, p1x2_ff, p1y2_ff, p1x3_ff, p1y3_ff;
   logic want_ff, want2_ff, want3_ff;
   logic signed [PW-1:0] m0_ff, m1_ff, m2_ff, m3_ff, m4_ff, m5_ff;
   logic signed [SW-1:0] dv_ff, nr_ff, ns_ff;
   logic signed [DW-1:0] ax_in, ay_in, bx_in, by_in, wx_in, wy_in;
   logic [SW-1:0] nr_neg, dv_neg, ns_neg, ax_neg, ay_neg;
   logic [MW-1:0] nr_mag, dv_mag, ns_mag;
   logic [DW-1:0] ax_mag, ay_mag;

   function automatic logic signed [DW-1:0] diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
      diff = $signed({a[CW-1], a}) - $signed({b[CW-1], b});
   endfunction

   function automatic logic in_unit(input logic signed [SW-1:0] n, input logic [MW-1:0] nm,
                                    input logic signed [SW-1:0] d, input logic [MW-1:0] dm);
      if (n == '0) begin
         in_unit = 1'b1;
      end else if (n[SW-1] != d[SW-1]) begin
         in_unit = 1'b0;
      end else begin
         in_unit = nm <= dm;
      end
   endfunction

   assign fe = !(f3_valid_ff && fifo_stat.full);
   assign req_tready = fe;

   assign ax_in = diff(req_tdata[2*CW +: CW], req_tdata[0 +: CW]);
   assign ay_in = diff(req_tdata[3*CW +: CW], req_tdata[CW +: CW]);
   assign bx_in = diff(req_tdata[6*CW +: CW], req_tdata[4*CW +: CW]);
   assign by_in = diff(req_tdata[7*CW +: CW], req_tdata[5*CW +: CW]);
   assign wx_in = diff(req_tdata[0 +: CW], req_tdata[4*CW +: CW]);
   assign wy_in = diff(req_tdata[CW +: CW], req_tdata[5*CW +: CW]);

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
         f3_valid_ff <= 1'b0;
      end else if (fe) begin
         f1_valid_ff <= req_tvalid;
         f2_valid_ff <= f1_valid_ff;
         f3_valid_ff <= f2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fe) begin
         ax_ff   <= ax_in;
         ay_ff   <= ay_in;
         bx_ff   <= bx_in;
         by_ff   <= by_in;
         wx_ff   <= wx_in;
         wy_ff   <= wy_in;
         p1x_ff  <= req_tdata[0 +: CW];
         p1y_ff  <= req_tdata[CW +: CW];
         want_ff <= req_tuser[0];
         m0_ff    <= ax_ff * by_ff;
         m1_ff    <= ay_ff * bx_ff;
         m2_ff    <= wy_ff * bx_ff;
         m3_ff    <= wx_ff * by_ff;
         m4_ff    <= wy_ff * ax_ff;
         m5_ff    <= wx_ff * ay_ff;
         ax2_ff   <= ax_ff;
         ay2_ff   <= ay_ff;
         p1x2_ff  <= p1x_ff;
         p1y2_ff  <= p1y_ff;
         want2_ff <= want_ff;
         dv_ff    <= SW'(m0_ff) - SW'(m1_ff);
         nr_ff    <= SW'(m2_ff) - SW'(m3_ff);
         ns_ff    <= SW'(m4_ff) - SW'(m5_ff);
         ax3_ff   <= ax2_ff;
         ay3_ff   <= ay2_ff;
         p1x3_ff  <= p1x2_ff;
         p1y3_ff  <= p1y2_ff;
         want3_ff <= want2_ff;
      end
   end

   always_comb begin
      nr_neg = -nr_ff;
      dv_neg = -dv_ff;
      ns_neg = -ns_ff;
      ax_neg = -SW'(ax3_ff);
      ay_neg = -SW'(ay3_ff);
      nr_mag = nr_ff[SW-1] ? nr_neg[MW-1:0] : nr_ff[MW-1:0];
      dv_mag = dv_ff[SW-1] ? dv_neg[MW-1:0] : dv_ff[MW-1:0];
      ns_mag = ns_ff[SW-1] ? ns_neg[MW-1:0] : ns_ff[MW-1:0];
      ax_mag = ax3_ff[DW-1] ? ax_neg[DW-1:0] : ax3_ff;
      ay_mag = ay3_ff[DW-1] ? ay_neg[DW-1:0] : ay3_ff;
      job.p1x    = p1x3_ff;
      job.p1y    = p1y3_ff;
      job.ax_mag = ax_mag;
      job.ay_mag = ay_mag;
      job.neg_x  = nr_ff[SW-1] ^ dv_ff[SW-1] ^ ax3_ff[DW-1];
      job.neg_y  = nr_ff[SW-1] ^ dv_ff[SW-1] ^ ay3_ff[DW-1];
      job.nr_mag = nr_mag;
      job.dv_mag = dv_mag;
      job.hit    = (dv_ff != '0) && in_unit(nr_ff, nr_mag, dv_ff, dv_mag)
                   && in_unit(ns_ff, ns_mag, dv_ff, dv_mag);
      job.want   = want3_ff;
      push = f3_valid_ff && !fifo_stat.full;
   end
endmodule
`default_nettype wire

FILE: sv/ssi_fifo.sv
// Short queue of classified transactions between the front and back ends.
// Depends on ssi_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ssi_fifo (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire ssi_pkg::job_type        push_job,
   input  wire logic                    pop,
   output ssi_pkg::job_type             pop_job,
   output ssi_pkg::fifo_stat_type       stat
);
   localparam int PtrW = ssi_pkg::FifoPtrWidth;
   localparam int CntW = ssi_pkg::FifoCntWidth;

   ssi_pkg::job_type  mem_ff [ssi_pkg::FifoDepth];
   logic [PtrW-1:0]   wr_ff, rd_ff;
   logic [CntW-1:0]   cnt_ff;

   always_comb begin
      stat.full  = cnt_ff == CntW'(ssi_pkg::FifoDepth);
      stat.empty = cnt_ff == '0;
      pop_job    = mem_ff[rd_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_job;
      end
   end

   `SSI_ASSERT(a_cnt_bound, cnt_ff <= CntW'(ssi_pkg::FifoDepth), "queue count above depth")
   `SSI_ASSERT(a_no_underflow, !(pop && stat.empty), "pop from empty queue")
   `SSI_ASSERT_NEXT(a_cnt_up, push && !pop, cnt_ff == $past(cnt_ff) + 1'b1, "count did not rise")
endmodule
`default_nettype wire

FILE: sv/ssi_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a remainder flag.
// Depends on ssi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ssi_div (
   input  wire logic                          clock,
   input  wire logic                          en,
   input  wire logic [ssi_pkg::NumWidth-1:0]  num,
   input  wire logic [ssi_pkg::MagWidth-1:0]  den,
   output logic [ssi_pkg::QuotWidth-1:0]      quot,
   output logic                               rem_nz
);
   localparam int QW = ssi_pkg::QuotWidth;
   localparam int MW = ssi_pkg::MagWidth;
   localparam int NW = ssi_pkg::NumWidth;

   logic [MW-1:0] rem_ff [QW];
   logic [QW-1:0] low_ff [QW];
   logic [QW-1:0] q_ff   [QW];
   logic [MW-1:0] d_ff   [QW];
   logic [MW-1:0] rem_in [QW];
   logic [QW-1:0] low_in [QW];
   logic [QW-1:0] q_in   [QW];
   logic [MW-1:0] d_in   [QW];

   always_comb begin
      logic [MW-1:0] r;
      logic [QW-1:0] l;
      logic [QW-1:0] q;
      logic [MW-1:0] d;
      logic [MW:0]   t;
      logic [MW:0]   diffv;
      logic          ge;
      for (int s = 0; s < QW; s++) begin
         if (s == 0) begin
            r = num[NW-1:QW];
            l = num[QW-1:0];
            q = '0;
            d = den;
         end else begin
            r = rem_ff[s-1];
            l = low_ff[s-1];
            q = q_ff[s-1];
            d = d_ff[s-1];
         end
         t         = {r, l[QW-1]};
         ge        = t >= {1'b0, d};
         diffv     = t - {1'b0, d};
         rem_in[s] = ge ? diffv[MW-1:0] : t[MW-1:0];
         low_in[s] = {l[QW-2:0], 1'b0};
         q_in[s]   = {q[QW-2:0], ge};
         d_in[s]   = d;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         low_ff <= low_in;
         q_ff   <= q_in;
         d_ff   <= d_in;
      end
   end

   assign quot   = q_ff[QW-1];
   assign rem_nz = rem_ff[QW-1] != '0;
endmodule
`default_nettype wire

FILE: sv/ssi_back.sv
// Back end: scales the line parameter, divides and rounds the crossing point.
// Depends on ssi_pkg, ssi_div and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ssi_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire ssi_pkg::fifo_stat_type  fifo_stat,
   input  wire ssi_pkg::job_type        job,
   output logic                         pop,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [31:0]                  rsp_tdata,
   output logic [0:0]                   rsp_tuser
);
   localparam int CW = ssi_pkg::CoordWidth;
   localparam int QW = ssi_pkg::QuotWidth;
   localparam int MW = ssi_pkg::MagWidth;
   localparam int NW = ssi_pkg::NumWidth;
   localparam int BW = ssi_pkg::BaseWidth;

   logic be;
   logic b0_valid_ff;
   logic [NW-1:0] nx_ff, ny_ff;
   logic [MW-1:0] d0_ff;
   logic signed [CW-1:0] b0_px_ff, b0_py_ff;
   logic b0_negx_ff, b0_negy_ff, b0_live_ff, b0_hit_ff;
   logic v_ff [QW];
   logic live_ff [QW];
   logic hit_ff [QW];
   logic negx_ff [QW];
   logic negy_ff [QW];
   logic signed [CW-1:0] px_ff [QW];
   logic signed [CW-1:0] py_ff [QW];
   logic [QW-1:0] qx, qy;
   logic fx, fy;
   logic rsp_valid_ff, rsp_hit_ff;
   logic [CW-1:0] rsp_x_ff, rsp_y_ff;
   logic [CW-1:0] cx_in, cy_in;

   function automatic logic [CW-1:0] fix(input logic [CW-1:0] p, input logic [QW-1:0] q,
                                         input logic neg, input logic frac);
      logic signed [BW-1:0] pe;
      logic signed [BW-1:0] qe;
      logic signed [BW-1:0] b;
      pe = $signed({{(BW-CW){p[CW-1]}}, p});
      qe = $signed({{(BW-QW){1'b0}}, q});
      if (!neg) begin
         b = pe + qe;
         if (frac && b[BW-1]) begin
            b = b + 1'b1;
         end
      end else begin
         b = pe - qe;
         if (frac && !b[BW-1] && b != '0) begin
            b = b - 1'b1;
         end
      end
      fix = b[CW-1:0];
   endfunction

   assign be  = !rsp_valid_ff || rsp_tready;
   assign pop = be && !fifo_stat.empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < QW; s++) begin
            v_ff[s] <= 1'b0;
         end
      end else if (be) begin
         b0_valid_ff  <= pop;
         v_ff[0]      <= b0_valid_ff;
         for (int s = 1; s < QW; s++) begin
            v_ff[s] <= v_ff[s-1];
         end
         rsp_valid_ff <= v_ff[QW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (be) begin
         nx_ff      <= NW'(job.nr_mag * job.ax_mag);
         ny_ff      <= NW'(job.nr_mag * job.ay_mag);
         d0_ff      <= job.dv_mag;
         b0_px_ff   <= job.p1x;
         b0_py_ff   <= job.p1y;
         b0_negx_ff <= job.neg_x;
         b0_negy_ff <= job.neg_y;
         b0_hit_ff  <= job.hit;
         b0_live_ff <= job.hit && job.want;
         live_ff[0] <= b0_live_ff;
         hit_ff[0]  <= b0_hit_ff;
         negx_ff[0] <= b0_negx_ff;
         negy_ff[0] <= b0_negy_ff;
         px_ff[0]   <= b0_px_ff;
         py_ff[0]   <= b0_py_ff;
         for (int s = 1; s < QW; s++) begin
            live_ff[s] <= live_ff[s-1];
            hit_ff[s]  <= hit_ff[s-1];
            negx_ff[s] <= negx_ff[s-1];
            negy_ff[s] <= negy_ff[s-1];
            px_ff[s]   <= px_ff[s-1];
            py_ff[s]   <= py_ff[s-1];
         end
         rsp_hit_ff <= hit_ff[QW-1];
         rsp_x_ff   <= cx_in;
         rsp_y_ff   <= cy_in;
      end
   end

   ssi_div u_div_x (
      .clock  (clock),
      .en     (be),
      .num    (nx_ff),
      .den    (d0_ff),
      .quot   (qx),
      .rem_nz (fx)
   );

   ssi_div u_div_y (
      .clock  (clock),
      .en     (be),
      .num    (ny_ff),
      .den    (d0_ff),
      .quot   (qy),
      .rem_nz (fy)
   );

   assign cx_in = live_ff[QW-1] ? fix(px_ff[QW-1], qx, negx_ff[QW-1], fx) : '0;
   assign cy_in = live_ff[QW-1] ? fix(py_ff[QW-1], qy, negy_ff[QW-1], fy) : '0;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_y_ff, rsp_x_ff};
   assign rsp_tuser  = rsp_hit_ff;

   `SSI_ASSERT(a_miss_zero, !(rsp_valid_ff && !rsp_hit_ff) || rsp_tdata == '0, "miss with point")
   `SSI_ASSERT_NEXT(a_hold, rsp_valid_ff && !rsp_tready,
      rsp_valid_ff && $stable(rsp_tdata) && $stable(rsp_tuser), "stall not held")
endmodule
`default_nettype wire

FILE: sv/segment_segment_intersection.sv
// Top level of the 2D segment intersection block: front end, queue and back end.
// Depends on ssi_pkg, ssi_front, ssi_fifo and ssi_back.
//
// Channel   Direction  Payload
// req_*     in         tdata: 8 signed Q12.4 coordinates; tuser: want_point
// rsp_*     out        tdata: cross_x, cross_y; tuser: hit
//
// One transaction is accepted per cycle unless the full queue stalls the front end.
// Results pass three front-end stages, the queue and the 17-stage quotient pipeline.
// Reset is synchronous and clears only the valid and queue control state.
// A stalled result holds the back end; the front end keeps filling the four-entry queue.
`timescale 1ns / 1ps
`default_nettype none
module segment_segment_intersection (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
   input  wire logic [127:0] req_tdata,
   // want_point
   input  wire logic [0:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // cross_x, cross_y
   output logic [31:0]       rsp_tdata,
   // hit
   output logic [0:0]        rsp_tuser
);
   ssi_pkg::fifo_stat_type fifo_stat;
   ssi_pkg::job_type       push_job, pop_job;
   logic                   push, pop;

   ssi_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .fifo_stat  (fifo_stat),
      .push       (push),
      .job        (push_job)
   );

   ssi_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .stat     (fifo_stat)
   );

   ssi_back u_back (
      .clock      (clock),
      .reset      (reset),
      .fifo_stat  (fifo_stat),
      .job        (pop_job),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );
endmodule
`default_nettype wire

FILE: tb/sv/tb_segment_segment_intersection.sv
// Self-checking testbench for segment_segment_intersection: drives segment pairs on the
// request stream and compares each response with an exact integer crossing predictor.
// Depends only on the top level of the block.
`timescale 1ns / 1ps
`default_nettype none
module tb_segment_segment_intersection;
   typedef struct {
      logic signed [15:0] c [8];
      logic               want;
   } seg_pair_type;

   typedef struct {
      logic        hit;
      logic [15:0] cx;
      logic [15:0] cy;
   } crossing_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;
   logic [0:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [31:0]  rsp_tdata;
   logic [0:0]   rsp_tuser;

   seg_pair_type pending_pairs [$];
   crossing_type expected_crossings [$];
   int        mismatches = 0;
   int        responses = 0;
   int        hits = 0;
   int        send_idle_pct = 32;
   int        recv_idle_pct = 64;
   int        hold_cycles = 0;

   segment_segment_intersection dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always #10 clock = ~clock;

   // Truncates p + nr*dl/dv toward zero; the ratio lies in the unit range.
   function automatic logic [15:0] along_segment(longint p, longint dl, longint nr,
                                                 longint dv);
      logic signed [127:0] num;
      logic signed [127:0] q;
      logic signed [127:0] r;
      num = 128'(nr) * 128'(dl);
      q = num / 128'(dv);
      r = num % 128'(dv);
      q = 128'(p) + q;
      // The true value lies strictly between q and its neighbour in the sign of num/dv.
      if (r != 0) begin
         if ((num < 0) != (dv < 0)) begin
            if (q > 0) q = q - 1;
         end else begin
            if (q < 0) q = q + 1;
         end
      end
      return q[15:0];
   endfunction

   function automatic logic within_unit(longint n, longint d);
      if (n == 0) return 1'b1;
      if ((n < 0) != (d < 0)) return 1'b0;
      return (n < 0 ? -n : n) <= (d < 0 ? -d : d);
   endfunction

   function automatic crossing_type predict_crossing(seg_pair_type s);
      crossing_type res;
      longint ax, ay, bx, by, wx, wy, dv, nr, ns;
      ax = longint'(s.c[2]) - s.c[0];
      ay = longint'(s.c[3]) - s.c[1];
      bx = longint'(s.c[6]) - s.c[4];
      by = longint'(s.c[7]) - s.c[5];
      wx = longint'(s.c[0]) - s.c[4];
      wy = longint'(s.c[1]) - s.c[5];
      dv = ax * by - ay * bx;
      nr = wy * bx - wx * by;
      ns = wy * ax - wx * ay;
      res = '{1'b0, 16'd0, 16'd0};
      if (dv != 0 && within_unit(nr, dv) && within_unit(ns, dv)) begin
         res.hit = 1'b1;
         if (s.want) begin
            res.cx = along_segment(s.c[0], ax, nr, dv);
            res.cy = along_segment(s.c[1], ay, nr, dv);
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
      $display("mismatch %s: got %0h expected %0h", what, got, exp);
      mismatches++;
   endtask

   task automatic queue_pair(logic signed [15:0] c0, c1, c2, c3, c4, c5, c6, c7,
                             logic want);
      seg_pair_type s;
      s.c = '{c0, c1, c2, c3, c4, c5, c6, c7};
      s.want = want;
      pending_pairs.push_back(s);
   endtask

   function automatic logic signed [15:0] rand_coord(int mode);
      case (mode)
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, 400)) - 16'sd200;
         default: return $urandom_range(0, 1) ? 16'sh7fff - 16'($urandom_range(0, 3))
                                                : 16'sh8000 + 16'($urandom_range(0, 3));
      endcase
   endfunction

   // Driver.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_pairs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            seg_pair_type s;
            s = pending_pairs.pop_front();
            expected_crossings.push_back(predict_crossing(s));
            req_tdata <= {s.c[7], s.c[6], s.c[5], s.c[4], s.c[3], s.c[2], s.c[1], s.c[0]};
            req_tuser <= s.want;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver readiness, with a long hold-off counted here.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= $urandom_range(0, 99) >= recv_idle_pct;
      end
   end

   // Monitor.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         crossing_type e;
         responses++;
         if (expected_crossings.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_tdata, 32'd0);
         end else begin
            e = expected_crossings.pop_front();
            hits += e.hit;
            if (rsp_tuser[0] !== e.hit) report_mismatch("hit", rsp_tuser, e.hit);
            if (rsp_tdata[15:0] !== e.cx) report_mismatch("cross_x", rsp_tdata[15:0], e.cx);
            if (rsp_tdata[31:16] !== e.cy)
               report_mismatch("cross_y", rsp_tdata[31:16], e.cy);
         end
      end
   end

   initial begin
      int mode;
      logic signed [15:0] t, u;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // Directed: crossing, touching ends, parallel, collinear, degenerate, extremes.
      queue_pair(-16, 0, 16, 0, 0, -16, 0, 16, 1);
      queue_pair(-16, 0, 16, 0, 0, -16, 0, 16, 0);
      queue_pair(0, 0, 32, 32, 32, 32, 64, 0, 1);
      queue_pair(0, 0, 32, 0, 0, 16, 32, 16, 1);
      queue_pair(0, 0, 32, 0, 16, 0, 48, 0, 1);
      queue_pair(5, 5, 5, 5, 0, 0, 10, 10, 1);
      queue_pair(0, 0, 10, 0, 20, -5, 20, 5, 1);
      queue_pair(0, 0, 7, 3, 0, 3, 7, 0, 1);
      queue_pair(0, 0, -7, -3, 0, -3, -7, 0, 1);
      queue_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768, 1);
      queue_pair(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768, 1);
      queue_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767, 1);
      queue_pair(-1, -1, -1, -1, -1, -1, -1, -1, 1);
      queue_pair(0, 0, 0, 0, 0, 0, 0, 0, 0);
      queue_pair(-32768, -32768, -32767, 32767, 32767, -1, -32768, 1, 1);
      queue_pair(3, 1, -5, 7, -2, -2, 4, 9, 1);
      for (int i = 0; i < 650; i++) begin
         if (i == 220) begin
            wait (pending_pairs.size() == 0);
            send_idle_pct = 64;
            recv_idle_pct = 32;
            hold_cycles = 200;
         end
         if (i == 440) begin
            wait (pending_pairs.size() == 0);
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         mode = $urandom_range(0, 9);
         if (mode < 6) begin
            // Most pairs are built to cross: endpoints straddle a shared centre.
            t = 16'($urandom_range(0, 2000)) - 16'sd1000;
            u = 16'($urandom_range(0, 2000)) - 16'sd1000;
            queue_pair(t - rand_coord(1), u - rand_coord(1), t + rand_coord(1),
                       u + rand_coord(1), t - rand_coord(1), u + rand_coord(1),
                       t + rand_coord(1), u - rand_coord(1), $urandom_range(0, 1));
         end else begin
            mode = (mode == 9) ? 2 : mode - 6;
            queue_pair(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                       rand_coord(mode), rand_coord(mode), rand_coord(mode),
                       rand_coord(mode), rand_coord(mode), $urandom_range(0, 1));
         end
      end
      wait (pending_pairs.size() == 0 && !req_tvalid);
      wait (expected_crossings.size() == 0);
      repeat (40) @(posedge clock);
      $display("covered %0d transactions, %0d of them crossings, under three stall mixes",
               responses, hits);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("timeout with %0d transactions outstanding", expected_crossings.size());
      $display("status: fail");
      $finish;
   end
endmodule
`default_nettype wire
